/* rtl/smi_pkg.sv */
// ----------------------------------------------------------------------------
// smi_pkg: shared types for the small matrix inverse core
// Word formats, dimension codes and the bundle that travels from the
// cofactor pipeline to the merge stage.
// ----------------------------------------------------------------------------
package smi_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int COF_BITS  = 2 * WORD_BITS + 1;
  localparam int DET_BITS  = 3 * WORD_BITS + 3;
  // divider lane depth: abs, numerator, range check, one stage per bit, final
  localparam int LANE_LAT  = WORD_BITS + 4;
  localparam int LANES     = 9;

  typedef enum logic [1:0] {
    DIM_EMPTY  = 2'd0,
    DIM_SCALAR = 2'd1,
    DIM_2X2    = 2'd2,
    DIM_3X3    = 2'd3
  } dim_t;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [COF_BITS-1:0]  cof_t;
  typedef logic signed [DET_BITS-1:0]  det_t;

  typedef struct packed {
    dim_t  dimension;
    word_t a00;
    word_t a01;
    word_t a02;
    word_t a10;
    word_t a11;
    word_t a12;
    word_t a20;
    word_t a21;
    word_t a22;
  } in_word_t;

  typedef struct packed {
    word_t inv00;
    word_t inv01;
    word_t inv02;
    word_t inv10;
    word_t inv11;
    word_t inv12;
    word_t inv20;
    word_t inv21;
    word_t inv22;
    word_t det_value;
    logic  singular;
    logic  saturated;
  } out_word_t;

  typedef struct packed {
    logic valid;
    dim_t dim;
    det_t det;
  } det_info_t;

endpackage

/* rtl/small_matrix_inverse_determinant_core.sv */
// ----------------------------------------------------------------------------
// small_matrix_inverse_determinant_core: 3x3 inverse and determinant
// Throughput one word per cycle when not stalled; the restoring divider lanes,
// one quotient bit per stage, set the depth. The whole pipeline holds while
// result_stall keeps a finished word in the output register.
// Reset clears all valid bits; no memories, no clearing pass.
// ----------------------------------------------------------------------------
module small_matrix_inverse_determinant_core #(
  parameter int FRAC_BITS = smi_pkg::FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  smi_pkg::in_word_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output smi_pkg::out_word_t  result
);

  // Data flow:
  //   smi_cof   4 stages  products, cofactors, determinant, adjugate select
  //   smi_lane  9 lanes   one per inverse entry, WORD_BITS + 4 stages each
  //   smi_merge           determinant rounding in parallel, masking, flags,
  //                       output register
  // Every register advances on one shared enable, open whenever the output
  // register is empty or being taken.

  logic                  en;
  logic                  load;
  smi_pkg::cof_t [8:0]   cof;
  smi_pkg::det_info_t    info;
  smi_pkg::word_t [8:0]  lane_word;
  logic           [8:0]  lane_sat;

  assign en         = !result_valid || !result_stall;
  assign item_stall = !en;
  assign load       = item_valid && en;

  smi_cof u_cof (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .load (load),
    .item (item),
    .cof  (cof),
    .info (info)
  );

  // one divider lane per adjugate entry, all fed the same determinant
  for (genvar k = 0; k < smi_pkg::LANES; k++) begin : g_lane
    smi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .en     (en),
      .cof    (cof[k]),
      .det    (info.det),
      .q_word (lane_word[k]),
      .q_sat  (lane_sat[k])
    );
  end

  smi_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .info      (info),
    .q_word    (lane_word),
    .q_sat     (lane_sat),
    .out_valid (result_valid),
    .out_word  (result)
  );

endmodule

/* rtl/smi_cof.sv */
// ----------------------------------------------------------------------------
// smi_cof: adjugate and determinant pipeline
// Four stages: pair products, cofactors, split determinant products,
// determinant sum with adjugate selection by dimension.
// ----------------------------------------------------------------------------
module smi_cof (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        load,
  input  smi_pkg::in_word_t           item,
  output smi_pkg::cof_t   [8:0]       cof,
  output smi_pkg::det_info_t          info
);

  localparam int W  = smi_pkg::WORD_BITS;
  localparam int CB = smi_pkg::COF_BITS;
  localparam int DB = smi_pkg::DET_BITS;

  // stage 1
  logic                   v1;
  smi_pkg::prod_t [17:0]  pr;
  smi_pkg::dim_t          dim1;
  smi_pkg::word_t         b00_1, b01_1, b02_1, b10_1, b11_1;
  // stage 2
  logic                   v2;
  smi_pkg::cof_t  [8:0]   cf2;
  smi_pkg::dim_t          dim2;
  smi_pkg::word_t         b00_2, b01_2, b02_2, b10_2, b11_2;
  // stage 3
  logic                   v3;
  smi_pkg::cof_t  [8:0]   cf3;
  logic signed [CB-1:0]   plo [0:2];
  logic signed [CB-1:0]   phi [0:2];
  smi_pkg::dim_t          dim3;
  smi_pkg::word_t         b00_3, b01_3, b10_3, b11_3;

  smi_pkg::det_t          d3_sum;
  // stage 4
  logic                   v4;
  smi_pkg::dim_t          dim4;
  smi_pkg::det_t          det4;
  smi_pkg::det_t          det_next;
  smi_pkg::cof_t  [8:0]   cof_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= load;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: the eighteen 2x2 minor products
  always_ff @(posedge clk) begin
    if (en) begin
      pr[0]  <= item.a11 * item.a22;
      pr[1]  <= item.a12 * item.a21;
      pr[2]  <= item.a02 * item.a21;
      pr[3]  <= item.a01 * item.a22;
      pr[4]  <= item.a01 * item.a12;
      pr[5]  <= item.a02 * item.a11;
      pr[6]  <= item.a12 * item.a20;
      pr[7]  <= item.a10 * item.a22;
      pr[8]  <= item.a00 * item.a22;
      pr[9]  <= item.a02 * item.a20;
      pr[10] <= item.a02 * item.a10;
      pr[11] <= item.a00 * item.a12;
      pr[12] <= item.a10 * item.a21;
      pr[13] <= item.a11 * item.a20;
      pr[14] <= item.a01 * item.a20;
      pr[15] <= item.a00 * item.a21;
      pr[16] <= item.a00 * item.a11;
      pr[17] <= item.a01 * item.a10;
      dim1   <= item.dimension;
      b00_1  <= item.a00;
      b01_1  <= item.a01;
      b02_1  <= item.a02;
      b10_1  <= item.a10;
      b11_1  <= item.a11;
    end
  end

  // stage 2: cofactors, row-major adjugate order
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        cf2[k] <= CB'(pr[2*k]) - CB'(pr[2*k+1]);
      end
      dim2  <= dim1;
      b00_2 <= b00_1;
      b01_2 <= b01_1;
      b02_2 <= b02_1;
      b10_2 <= b10_1;
      b11_2 <= b11_1;
    end
  end

  // stage 3: first row times first adjugate column, cofactor split at W
  always_ff @(posedge clk) begin
    if (en) begin
      plo[0] <= b00_2 * $signed({1'b0, cf2[0][W-1:0]});
      phi[0] <= b00_2 * $signed(cf2[0][CB-1:W]);
      plo[1] <= b01_2 * $signed({1'b0, cf2[3][W-1:0]});
      phi[1] <= b01_2 * $signed(cf2[3][CB-1:W]);
      plo[2] <= b02_2 * $signed({1'b0, cf2[6][W-1:0]});
      phi[2] <= b02_2 * $signed(cf2[6][CB-1:W]);
      cf3    <= cf2;
      dim3   <= dim2;
      b00_3  <= b00_2;
      b01_3  <= b01_2;
      b10_3  <= b10_2;
      b11_3  <= b11_2;
    end
  end

  always_comb begin
    d3_sum = '0;
    for (int k = 0; k < 3; k++) begin
      d3_sum = d3_sum + (DB'(phi[k]) <<< W) + DB'(plo[k]);
    end
  end

  // stage 4: pick determinant and adjugate for the dimension in use
  always_comb begin
    cof_next = '0;
    case (dim3)
      smi_pkg::DIM_3X3: begin
        det_next = d3_sum;
        cof_next = cf3;
      end
      smi_pkg::DIM_2X2: begin
        det_next    = DB'(cf3[8]);
        cof_next[0] = CB'(b11_3);
        cof_next[1] = -CB'(b01_3);
        cof_next[3] = -CB'(b10_3);
        cof_next[4] = CB'(b00_3);
      end
      smi_pkg::DIM_SCALAR: begin
        det_next    = DB'(b00_3);
        cof_next[0] = CB'(1);
      end
      default: begin
        det_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dim4 <= dim3;
      det4 <= det_next;
      cof  <= cof_next;
    end
  end

  assign info = '{valid: v4, dim: dim4, det: det4};

endmodule

/* rtl/smi_lane.sv */
// ----------------------------------------------------------------------------
// smi_lane: one inverse entry
// Rounded, saturated quotient adjugate * 2^(2F) / det, restoring divider
// with one quotient bit per stage.
// ----------------------------------------------------------------------------
module smi_lane #(
  parameter int FRAC_BITS = smi_pkg::FRAC_BITS
) (
  input  logic           clk,
  input  logic           en,
  input  smi_pkg::cof_t  cof,
  input  smi_pkg::det_t  det,
  output smi_pkg::word_t q_word,
  output logic           q_sat
);

  localparam int W        = smi_pkg::WORD_BITS;
  localparam int CB       = smi_pkg::COF_BITS;
  localparam int DB       = smi_pkg::DET_BITS;
  localparam int SH       = 2 * FRAC_BITS + 1;
  localparam int NUM_A    = CB + SH;
  localparam int NUM_BITS = ((NUM_A > DB) ? NUM_A : DB) + 1;
  localparam int DD_BITS  = DB + 1;
  localparam int CMP_BITS = (NUM_BITS > DD_BITS + W) ? NUM_BITS : DD_BITS + W;

  logic [CB-1:0]       cmag0;
  logic [DB-1:0]       dmag0;
  logic                neg0;
  logic [NUM_BITS-1:0] num1;
  logic [DD_BITS-1:0]  dd1;
  logic                neg1;

  logic [CMP_BITS-1:0] rem  [0:W-1];
  logic [DD_BITS-1:0]  ddp  [0:W-1];
  logic [W-1:0]        qv   [0:W];
  logic                negp [0:W];
  logic                hugep[0:W];

  logic [W-1:0]        lim;
  logic [W-1:0]        mag_f;
  logic                sat_f;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    if (en) begin
      cmag0 <= cof[CB-1] ? CB'(-cof) : CB'(cof);
      dmag0 <= det[DB-1] ? DB'(-det) : DB'(det);
      neg0  <= cof[CB-1] ^ det[DB-1];
    end
  end

  // 2m + den over 2den gives round half away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      num1 <= (NUM_BITS'(cmag0) << SH) + NUM_BITS'(dmag0);
      dd1  <= {dmag0, 1'b0};
      neg1 <= neg0;
    end
  end

  // quotient of 2^W or more can only saturate
  always_ff @(posedge clk) begin
    if (en) begin
      hugep[0] <= CMP_BITS'(num1) >= (CMP_BITS'(dd1) << W);
      rem[0]   <= CMP_BITS'(num1);
      ddp[0]   <= dd1;
      qv[0]    <= '0;
      negp[0]  <= neg1;
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_bit
    localparam int K = W - 1 - s;
    logic [CMP_BITS-1:0] sub;
    logic                take;
    assign sub  = CMP_BITS'(ddp[s]) << K;
    assign take = rem[s] >= sub;

    always_ff @(posedge clk) begin
      if (en) begin
        qv[s+1]    <= take ? (qv[s] | (W'(1) << K)) : qv[s];
        negp[s+1]  <= negp[s];
        hugep[s+1] <= hugep[s];
      end
    end

    if (s < W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= take ? (rem[s] - sub) : rem[s];
          ddp[s+1] <= ddp[s];
        end
      end
    end
  end

  // saturate to the signed word
  always_comb begin
    lim   = negp[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
    sat_f = hugep[W] || (qv[W] > lim);
    mag_f = sat_f ? lim : qv[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_word <= $signed(negp[W] ? (W'(0) - mag_f) : mag_f);
      q_sat  <= sat_f;
    end
  end

endmodule

/* rtl/smi_merge.sv */
// ----------------------------------------------------------------------------
// smi_merge: determinant rounding and result assembly
// Rounds the determinant while the lanes divide, then masks lanes by
// dimension and singularity and drives the output register.
// ----------------------------------------------------------------------------
module smi_merge #(
  parameter int FRAC_BITS = smi_pkg::FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  smi_pkg::det_info_t          info,
  input  smi_pkg::word_t [8:0]        q_word,
  input  logic           [8:0]        q_sat,
  output logic                        out_valid,
  output smi_pkg::out_word_t          out_word
);

  localparam int W   = smi_pkg::WORD_BITS;
  localparam int DB  = smi_pkg::DET_BITS;
  localparam int DLY = smi_pkg::LANE_LAT - 2;

  typedef struct packed {
    smi_pkg::dim_t  dim;
    smi_pkg::word_t det_word;
    logic           det_sat;
    logic           sing;
  } det_res_t;

  logic            va, vb;
  smi_pkg::dim_t   dim_a, dim_b;
  logic [DB-1:0]   mag_a, qb;
  logic            neg_a, neg_b, sing_a, sing_b;

  logic [DB-1:0]   lim_c;
  logic            sat_c;
  logic [W-1:0]    mag_c;

  logic            vd  [0:DLY-1];
  det_res_t        dly [0:DLY-1];

  det_res_t           fin;
  smi_pkg::word_t [8:0] inv;
  logic           [8:0] act;
  smi_pkg::out_word_t   out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < DLY; k++) vd[k] <= 1'b0;
    end else if (en) begin
      va        <= info.valid;
      vb        <= va;
      vd[0]     <= vb;
      for (int k = 1; k < DLY; k++) vd[k] <= vd[k-1];
      out_valid <= vd[DLY-1];
    end
  end

  // magnitude and singular test
  always_ff @(posedge clk) begin
    if (en) begin
      dim_a  <= info.dim;
      mag_a  <= info.det[DB-1] ? DB'(-info.det) : DB'(info.det);
      neg_a  <= info.det[DB-1];
      sing_a <= (info.dim != smi_pkg::DIM_EMPTY) && (info.det == '0);
    end
  end

  // drop the extra fraction bits with rounding; an empty matrix gives 1.0
  always_ff @(posedge clk) begin
    if (en) begin
      dim_b  <= dim_a;
      sing_b <= sing_a;
      neg_b  <= (dim_a == smi_pkg::DIM_EMPTY) ? 1'b0 : neg_a;
      case (dim_a)
        smi_pkg::DIM_EMPTY:  qb <= DB'(1) << FRAC_BITS;
        smi_pkg::DIM_SCALAR: qb <= mag_a;
        smi_pkg::DIM_2X2:
          qb <= (mag_a + (DB'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        smi_pkg::DIM_3X3:
          qb <= (mag_a + (DB'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        default: qb <= mag_a;
      endcase
    end
  end

  always_comb begin
    lim_c = neg_b ? (DB'(1) << (W - 1)) : ((DB'(1) << (W - 1)) - DB'(1));
    sat_c = qb > lim_c;
    mag_c = sat_c ? lim_c[W-1:0] : qb[W-1:0];
  end

  // saturate, then wait out the divider lanes
  always_ff @(posedge clk) begin
    if (en) begin
      dly[0].dim      <= dim_b;
      dly[0].det_word <= $signed(neg_b ? (W'(0) - mag_c) : mag_c);
      dly[0].det_sat  <= sat_c;
      dly[0].sing     <= sing_b;
      for (int k = 1; k < DLY; k++) dly[k] <= dly[k-1];
    end
  end

  assign fin = dly[DLY-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        act[i*3+j] = (2'(i) < fin.dim) && (2'(j) < fin.dim) && !fin.sing;
        inv[i*3+j] = act[i*3+j] ? q_word[i*3+j] : '0;
      end
    end
    out_next.inv00     = inv[0];
    out_next.inv01     = inv[1];
    out_next.inv02     = inv[2];
    out_next.inv10     = inv[3];
    out_next.inv11     = inv[4];
    out_next.inv12     = inv[5];
    out_next.inv20     = inv[6];
    out_next.inv21     = inv[7];
    out_next.inv22     = inv[8];
    out_next.det_value = fin.det_word;
    out_next.singular  = fin.sing;
    out_next.saturated = fin.det_sat || ((act & q_sat) != '0);
  end

  always_ff @(posedge clk) begin
    if (en) out_word <= out_next;
  end

  a_sing_det: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.singular |-> out_word.det_value == '0)
    else $error("singular result with nonzero determinant");

  a_sing_inv: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.singular |->
      out_word.inv00 == '0 && out_word.inv01 == '0 && out_word.inv02 == '0 &&
      out_word.inv10 == '0 && out_word.inv11 == '0 && out_word.inv12 == '0 &&
      out_word.inv20 == '0 && out_word.inv21 == '0 && out_word.inv22 == '0)
    else $error("singular result with nonzero inverse entry");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vd[DLY-1]) && $past(en))
    else $error("output word without a pipeline item");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for small_matrix_inverse_determinant_core
// Drives matrix words through the valid/stall channel and checks every result
// word, field by field and in order, against typed values or a wide-integer
// predictor of adjugate/determinant math with round-half-away and saturation.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // 192 bits covers the largest numerator, cofactor << 32, with headroom
  typedef logic signed [191:0] wide_t;

  typedef struct {
    smi_pkg::in_word_t  word;
    bit                 typed;
    smi_pkg::out_word_t res;
  } stim_row_t;

  localparam int RAND_ITEMS = 1700;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 3 * (smi_pkg::WORD_BITS + 9);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  smi_pkg::in_word_t   item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  smi_pkg::out_word_t  result;

  smi_pkg::out_word_t  expected_q[$];
  int         mismatches = 0;
  bit         quiet = 1'b0;     // no idling on either side
  bit         hold_go = 1'b0;   // ask the receiver for one long hold-off
  bit         hold_done = 1'b0;

  small_matrix_inverse_determinant_core u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Round num/den to nearest, ties away from zero, then clip to a word.
  function automatic smi_pkg::word_t round_clip(input wide_t num, input wide_t den,
                                                inout logic sat);
    wide_t mag, q, lim;
    logic  neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (2 * mag + den) / (2 * den);
    lim = neg ? (wide_t'(1) <<< (smi_pkg::WORD_BITS - 1))
              : (wide_t'(1) <<< (smi_pkg::WORD_BITS - 1)) - 1;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? smi_pkg::word_t'(-q) : smi_pkg::word_t'(q);
  endfunction

  function automatic smi_pkg::out_word_t predict_inverse(input smi_pkg::in_word_t w);
    wide_t              a[3][3];
    wide_t              c[3][3];
    wide_t              d, den;
    smi_pkg::word_t     inv[3][3];
    logic               sat;
    int                 n;
    smi_pkg::out_word_t r;
    a[0][0] = w.a00; a[0][1] = w.a01; a[0][2] = w.a02;
    a[1][0] = w.a10; a[1][1] = w.a11; a[1][2] = w.a12;
    a[2][0] = w.a20; a[2][1] = w.a21; a[2][2] = w.a22;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        c[i][j] = 0;
        inv[i][j] = '0;
      end
    sat = 1'b0;
    n = int'(w.dimension);
    r = '0;
    if (w.dimension == smi_pkg::DIM_EMPTY) begin
      r.det_value = round_clip(wide_t'(1) <<< smi_pkg::FRAC_BITS, 1, sat);
      r.saturated = sat;
      return r;
    end
    if (w.dimension == smi_pkg::DIM_SCALAR) begin
      d = a[0][0];
      c[0][0] = 1;
    end else if (w.dimension == smi_pkg::DIM_2X2) begin
      d = a[0][0] * a[1][1] - a[0][1] * a[1][0];
      c[0][0] = a[1][1];
      c[0][1] = -a[0][1];
      c[1][0] = -a[1][0];
      c[1][1] = a[0][0];
    end else begin
      c[0][0] = a[1][1] * a[2][2] - a[1][2] * a[2][1];
      c[0][1] = a[0][2] * a[2][1] - a[0][1] * a[2][2];
      c[0][2] = a[0][1] * a[1][2] - a[0][2] * a[1][1];
      c[1][0] = a[1][2] * a[2][0] - a[1][0] * a[2][2];
      c[1][1] = a[0][0] * a[2][2] - a[0][2] * a[2][0];
      c[1][2] = a[0][2] * a[1][0] - a[0][0] * a[1][2];
      c[2][0] = a[1][0] * a[2][1] - a[1][1] * a[2][0];
      c[2][1] = a[0][1] * a[2][0] - a[0][0] * a[2][1];
      c[2][2] = a[0][0] * a[1][1] - a[0][1] * a[1][0];
      d = a[0][0] * c[0][0] + a[0][1] * c[1][0] + a[0][2] * c[2][0];
    end
    r.det_value = round_clip(d, wide_t'(1) <<< ((n - 1) * smi_pkg::FRAC_BITS), sat);
    if (d == 0) begin
      r.singular = 1'b1;
    end else begin
      den = (d < 0) ? -d : d;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++)
          inv[i][j] = round_clip((d < 0) ? -(c[i][j] <<< (2 * smi_pkg::FRAC_BITS))
                                         : (c[i][j] <<< (2 * smi_pkg::FRAC_BITS)),
                                 den, sat);
    end
    r.inv00 = inv[0][0]; r.inv01 = inv[0][1]; r.inv02 = inv[0][2];
    r.inv10 = inv[1][0]; r.inv11 = inv[1][1]; r.inv12 = inv[1][2];
    r.inv20 = inv[2][0]; r.inv21 = inv[2][1]; r.inv22 = inv[2][2];
    r.saturated = sat;
    return r;
  endfunction

  function automatic smi_pkg::word_t rand_entry();
    case ($urandom_range(0, 9))
      0: return smi_pkg::word_t'(32'h8000_0000);
      1: return smi_pkg::word_t'(32'h7fff_ffff);
      2, 3: return smi_pkg::word_t'($urandom);
      4: return smi_pkg::word_t'($signed($urandom_range(0, 64)) - 32);
      default: return smi_pkg::word_t'(($signed($urandom_range(0, 16)) - 8) * 65536
                                       + $signed($urandom_range(0, 65535)));
    endcase
  endfunction

  function automatic smi_pkg::in_word_t rand_matrix();
    smi_pkg::in_word_t w;
    w.dimension = smi_pkg::dim_t'($urandom_range(0, 3));
    w.a00 = rand_entry(); w.a01 = rand_entry(); w.a02 = rand_entry();
    w.a10 = rand_entry(); w.a11 = rand_entry(); w.a12 = rand_entry();
    w.a20 = rand_entry(); w.a21 = rand_entry(); w.a22 = rand_entry();
    // sometimes repeat row 0 as row 1, making a 2x2 or 3x3 matrix singular
    if ($urandom_range(0, 9) == 0) begin
      w.a10 = w.a00; w.a11 = w.a01; w.a12 = w.a02;
    end
    return w;
  endfunction

  function automatic bit idle_now();
    return !quiet && ($urandom_range(0, 99) < 22);
  endfunction

  // Offer one word and wait for its acceptance; queue its expected result.
  task automatic send_word(input smi_pkg::in_word_t w, input smi_pkg::out_word_t res);
    while (idle_now()) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!(item_valid && !item_stall));
    expected_q.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v, inout bit bad);
    if (exp_v !== got_v) begin
      if (mismatches < 10)
        $display("%0t: %s expected %h got %h", $realtime, name, exp_v, got_v);
      bad = 1'b1;
    end
  endtask

  // Result checker: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    smi_pkg::out_word_t e;
    bit                 bad;
    if (!rst && result_valid && !result_stall) begin
      bad = 1'b0;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("%0t: unexpected result word", $realtime);
        mismatches++;
      end else begin
        e = expected_q.pop_front();
        check_field("inv00", e.inv00, result.inv00, bad);
        check_field("inv01", e.inv01, result.inv01, bad);
        check_field("inv02", e.inv02, result.inv02, bad);
        check_field("inv10", e.inv10, result.inv10, bad);
        check_field("inv11", e.inv11, result.inv11, bad);
        check_field("inv12", e.inv12, result.inv12, bad);
        check_field("inv20", e.inv20, result.inv20, bad);
        check_field("inv21", e.inv21, result.inv21, bad);
        check_field("inv22", e.inv22, result.inv22, bad);
        check_field("det_value", e.det_value, result.det_value, bad);
        check_field("singular", e.singular, result.singular, bad);
        check_field("saturated", e.saturated, result.saturated, bad);
        if (bad) mismatches++;
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done && hold_cnt == 0) begin
        hold_cnt = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= idle_now();
      end
    end
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    stim_row_t          rows[$];
    stim_row_t          row;
    smi_pkg::in_word_t  w;
    smi_pkg::out_word_t r;

    // Directed rows. Typed results only where obvious.
    w = '0; w.dimension = smi_pkg::DIM_EMPTY;
    r = '0; r.det_value = 32'h0001_0000;
    rows.push_back('{w, 1'b1, r});
    w = '1; w.dimension = smi_pkg::DIM_EMPTY;           // entries ignored
    rows.push_back('{w, 1'b1, r});
    w = '1; w.dimension = smi_pkg::DIM_SCALAR; w.a00 = 32'h0001_0000;
    r = '0; r.inv00 = 32'h0001_0000; r.det_value = 32'h0001_0000;
    rows.push_back('{w, 1'b1, r});
    w = '1; w.dimension = smi_pkg::DIM_SCALAR; w.a00 = '0;   // singular scalar
    r = '0; r.singular = 1'b1;
    rows.push_back('{w, 1'b1, r});
    w = '0; w.dimension = smi_pkg::DIM_SCALAR; w.a00 = 32'sd1;  // tiny, inverse clips
    r = '0; r.inv00 = 32'h7fff_ffff; r.det_value = 32'sd1; r.saturated = 1'b1;
    rows.push_back('{w, 1'b1, r});
    w = '0; w.dimension = smi_pkg::DIM_SCALAR; w.a00 = 32'h8000_0000;
    rows.push_back('{w, 1'b0, r});
    w = '0; w.dimension = smi_pkg::DIM_SCALAR; w.a00 = 32'h7fff_ffff;
    rows.push_back('{w, 1'b0, r});
    w = '0; w.dimension = smi_pkg::DIM_SCALAR; w.a00 = -32'sd1;
    rows.push_back('{w, 1'b0, r});
    w = '1; w.dimension = smi_pkg::DIM_2X2; w.a00 = 32'h0001_0000; w.a01 = '0;
    w.a10 = '0; w.a11 = 32'h0001_0000;
    r = '0; r.inv00 = 32'h0001_0000; r.inv11 = 32'h0001_0000;
    r.det_value = 32'h0001_0000;
    rows.push_back('{w, 1'b1, r});
    w = '0; w.dimension = smi_pkg::DIM_2X2; w.a00 = 32'h0002_0000;
    w.a01 = 32'h0003_0000;
    w.a10 = 32'h0002_0000; w.a11 = 32'h0003_0000;   // equal rows
    r = '0; r.singular = 1'b1;
    rows.push_back('{w, 1'b1, r});
    w = '0; w.dimension = smi_pkg::DIM_2X2; w.a00 = 32'h7fff_ffff;
    w.a01 = 32'h8000_0000;
    w.a10 = 32'h8000_0000; w.a11 = 32'h7fff_ffff;
    rows.push_back('{w, 1'b0, r});
    w = '0; w.dimension = smi_pkg::DIM_2X2; w.a00 = 32'sd1; w.a11 = 32'sd1;  // tiny det
    rows.push_back('{w, 1'b0, r});
    w = '0; w.dimension = smi_pkg::DIM_3X3; w.a00 = 32'h0001_0000;
    w.a11 = 32'h0001_0000;
    w.a22 = 32'h0001_0000;
    r = '0; r.inv00 = 32'h0001_0000; r.inv11 = 32'h0001_0000;
    r.inv22 = 32'h0001_0000; r.det_value = 32'h0001_0000;
    rows.push_back('{w, 1'b1, r});
    w = '0; w.dimension = smi_pkg::DIM_3X3;
    r = '0; r.singular = 1'b1;
    rows.push_back('{w, 1'b1, r});
    w = {smi_pkg::DIM_3X3, {9{32'h8000_0000}}};
    rows.push_back('{w, 1'b0, r});
    w = {smi_pkg::DIM_3X3, {9{32'h7fff_ffff}}};
    rows.push_back('{w, 1'b0, r});
    w = '0; w.dimension = smi_pkg::DIM_3X3; w.a00 = 32'sd1; w.a11 = 32'sd1;
    w.a22 = 32'sd1;
    rows.push_back('{w, 1'b0, r});
    w = {smi_pkg::DIM_3X3, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000,
         32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000,
         32'h0000_8000, 32'h0003_0000, 32'h8000_0000};
    rows.push_back('{w, 1'b0, r});
    w = {smi_pkg::DIM_3X3, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000,
         32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
         32'h0000_0000, 32'h0001_0000, 32'h0002_0000};
    rows.push_back('{w, 1'b0, r});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      row = rows[k];
      send_word(row.word, row.typed ? row.res : predict_inverse(row.word));
    end

    for (int k = 0; k < RAND_ITEMS; k++) begin
      quiet = (k >= 700 && k < 1000);
      if (k == 300) hold_go = 1'b1;   // receiver backs up the pipeline
      if (k == 1200) begin              // sender waits for a full drain
        item_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      w = rand_matrix();
      send_word(w, predict_inverse(w));
    end
    item_valid <= 1'b0;
    quiet = 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/smi_pkg.sv
rtl/smi_cof.sv
rtl/smi_lane.sv
rtl/smi_merge.sv
rtl/small_matrix_inverse_determinant_core.sv
sim/tb.sv
